@@ hdl/rsti_pkg.sv @@
package rsti_pkg;

  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned RADIX_W  = 6;
  localparam int unsigned DIGIT_W  = 6;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned OFFOUT_W = 16;

  // Bases and radix codes.
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_AUTO  = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_OCT    = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC    = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX    = 6'd16;
  localparam logic [RADIX_W-1:0] BASE_MIN    = 6'd2;
  localparam logic [RADIX_W-1:0] BASE_MAX    = 6'd36;
  localparam logic [DIGIT_W-1:0] NO_DIGIT    = 6'h3F;

  // Character codes.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UP_A  = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LO_A  = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CHAR_W-1:0] CH_UP_X  = 8'h58;
  localparam logic [CHAR_W-1:0] CH_LO_X  = 8'h78;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] UP_OFF   = 8'd55;  // 'A' - 10
  localparam logic [CHAR_W-1:0] LO_OFF   = 8'd87;  // 'a' - 10

  localparam logic [VALUE_W-1:0] MAG_POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [VALUE_W-1:0] MAG_NEG_LIMIT = 64'h8000_0000_0000_0000;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SPACE,
    PH_SIGNED,
    PH_ZERO,
    PH_DIGITS
  } phase_t;

  // One character after classification.
  typedef struct packed {
    logic               start;
    logic               space;
    logic               sign;
    logic               minus;
    logic               zero;
    logic               x_mark;
    logic [DIGIT_W-1:0] digit;
  } cls_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ hdl/rsti_chan_if.sv @@
interface rsti_in_if;
  import rsti_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              start_req;
  modport source (output valid, char_code, start_req, input ready);
  modport sink (input valid, char_code, start_req, output ready);
endinterface

interface rsti_out_if;
  import rsti_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  value;
  logic        [OFFOUT_W-1:0] end_offset;
  logic                       overflowed;
  logic                       digits_found;
  modport source (output valid, value, end_offset, overflowed, digits_found, input ready);
  modport sink (input valid, value, end_offset, overflowed, digits_found, output ready);
endinterface

interface rsti_cfg_if;
  import rsti_pkg::*;
  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] radix;
  modport source (output valid, radix, input ready);
  modport sink (input valid, radix, output ready);
endinterface

@@ hdl/rsti_front.sv @@
module rsti_front (
  rsti_in_if.sink           in_ch,
  input  rsti_pkg::q_stat_t q_stat,
  output logic              push,
  output rsti_pkg::cls_t    push_data
);
  import rsti_pkg::*;

  logic [CHAR_W-1:0] c;

  assign c           = in_ch.char_code;
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  always_comb begin
    push_data.start  = in_ch.start_req;
    push_data.space  = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    push_data.sign   = (c == CH_PLUS) || (c == CH_MINUS);
    push_data.minus  = (c == CH_MINUS);
    push_data.zero   = (c == CH_ZERO);
    push_data.x_mark = (c == CH_UP_X) || (c == CH_LO_X);
    if (c >= CH_ZERO && c <= CH_NINE) begin
      push_data.digit = DIGIT_W'(c - CH_ZERO);
    end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
      push_data.digit = DIGIT_W'(c - UP_OFF);
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      push_data.digit = DIGIT_W'(c - LO_OFF);
    end else begin
      push_data.digit = NO_DIGIT;
    end
  end

endmodule

@@ hdl/rsti_queue.sv @@
module rsti_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  rsti_pkg::cls_t    push_data,
  input  logic              pop,
  output rsti_pkg::cls_t    head,
  output rsti_pkg::q_stat_t q_stat
);
  import rsti_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cls_t          slot_r [DEPTH];
  logic [IW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [IW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == CW'(DEPTH));
  assign head         = slot_r[rd_ptr_r];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == IW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == IW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

@@ hdl/rsti_back.sv @@
module rsti_back #(
  parameter int OFFSET_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [rsti_pkg::RADIX_W-1:0]     radix,
  input  rsti_pkg::cls_t                   head,
  input  rsti_pkg::q_stat_t                q_stat,
  output logic                             pop,
  rsti_out_if.source                       out_ch
);
  import rsti_pkg::*;

  localparam int PW = VALUE_W + RADIX_W + 1;

  phase_t                    phase_r, phase_nxt;
  logic                      neg_r, neg_nxt;
  logic [RADIX_W-1:0]        base_r, base_nxt;
  logic [VALUE_W-1:0]        acc_r, acc_nxt;
  logic                      any_r, any_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [OFFSET_WIDTH-1:0]   pos_r, pos_nxt;

  logic                      out_valid_r, out_valid_nxt;
  logic signed [VALUE_W-1:0] out_value_r;
  logic [OFFOUT_W-1:0]       out_offset_r;
  logic                      out_ovf_r, out_any_r;

  // Decoded step of the current entry.
  phase_t                    base_phase;
  logic                      live, skip_ws, take_sign, signed_step, zero_pref;
  logic                      signed_digit, zero_step, x_taken, zero_digit, digit_run;
  logic                      do_digit, base_ok, ends, add;
  logic [RADIX_W-1:0]        step_base;
  logic                      neg_eff, ovf_eff, any_eff;
  logic [VALUE_W-1:0]        acc_eff, limit;
  logic [OFFSET_WIDTH-1:0]   pos_eff;
  logic [31:0]               pos_ext;
  logic [PW-1:0]             prod;

  assign pop = !q_stat.empty && (!out_valid_r || out_ch.ready);

  always_comb begin
    base_phase   = head.start ? PH_SPACE : phase_r;
    live         = head.start || (phase_r != PH_IDLE);
    skip_ws      = live && (base_phase == PH_SPACE) && head.space;
    take_sign    = live && (base_phase == PH_SPACE) && !head.space && head.sign;
    signed_step  = live && (((base_phase == PH_SPACE) && !head.space && !head.sign)
                   || (base_phase == PH_SIGNED));
    zero_pref    = signed_step && head.zero && (radix == RADIX_AUTO || radix == BASE_HEX);
    signed_digit = signed_step && !zero_pref;
    zero_step    = live && (base_phase == PH_ZERO);
    x_taken      = zero_step && head.x_mark;
    zero_digit   = zero_step && !head.x_mark;
    digit_run    = live && (base_phase == PH_DIGITS);
    do_digit     = signed_digit || zero_digit || digit_run;

    if (signed_digit) begin
      step_base = (radix == RADIX_AUTO) ? BASE_DEC : radix;
    end else if (zero_digit) begin
      step_base = (base_r == RADIX_AUTO) ? BASE_OCT : BASE_HEX;
    end else if (x_taken) begin
      step_base = BASE_HEX;
    end else begin
      step_base = base_r;
    end

    base_ok = (step_base >= BASE_MIN) && (step_base <= BASE_MAX);
    ends    = do_digit && (!base_ok || (head.digit >= step_base));
    add     = do_digit && !ends;

    neg_eff = head.start ? 1'b0 : neg_r;
    acc_eff = head.start ? '0 : acc_r;
    ovf_eff = head.start ? 1'b0 : ovf_r;
    // A leading zero in front of a non-x character counts as a digit.
    any_eff = (head.start ? 1'b0 : any_r) || zero_digit;
    if (head.start) begin
      pos_eff = '0;
    end else if (pos_r != '1) begin
      pos_eff = pos_r + 1'b1;
    end else begin
      pos_eff = pos_r;
    end
    pos_ext = 32'(pos_eff);
    limit   = neg_eff ? MAG_NEG_LIMIT : MAG_POS_LIMIT;
    prod    = PW'(acc_eff) * PW'(step_base) + PW'(head.digit);
  end

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    if (pop && live) begin
      if (ends) begin
        phase_nxt = PH_IDLE;
      end else if (skip_ws) begin
        phase_nxt = PH_SPACE;
      end else if (take_sign) begin
        phase_nxt = PH_SIGNED;
      end else if (zero_pref) begin
        phase_nxt = PH_ZERO;
      end else begin
        phase_nxt = PH_DIGITS;
      end
    end
  end

  // Datapath and result.
  always_comb begin
    neg_nxt       = neg_r;
    base_nxt      = base_r;
    acc_nxt       = acc_r;
    any_nxt       = any_r;
    ovf_nxt       = ovf_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop && live) begin
      neg_nxt = take_sign ? head.minus : neg_eff;
      if (zero_pref) begin
        base_nxt = radix;
      end else if (do_digit || x_taken) begin
        base_nxt = step_base;
      end else if (head.start) begin
        base_nxt = '0;
      end
      acc_nxt = acc_eff;
      ovf_nxt = ovf_eff;
      any_nxt = any_eff || add;
      pos_nxt = pos_eff;
      if (add && !ovf_eff) begin
        if (prod > PW'(limit)) begin
          ovf_nxt = 1'b1;
          acc_nxt = limit;
        end else begin
          acc_nxt = prod[VALUE_W-1:0];
        end
      end
      if (ends) begin
        out_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      neg_r       <= 1'b0;
      base_r      <= '0;
      acc_r       <= '0;
      any_r       <= 1'b0;
      ovf_r       <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      neg_r       <= neg_nxt;
      base_r      <= base_nxt;
      acc_r       <= acc_nxt;
      any_r       <= any_nxt;
      ovf_r       <= ovf_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && ends) begin
      out_value_r  <= neg_eff ? VALUE_W'(-acc_eff) : acc_eff;
      out_offset_r <= any_eff ? pos_ext[OFFOUT_W-1:0] : '0;
      out_ovf_r    <= ovf_eff;
      out_any_r    <= any_eff;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.value        = out_value_r;
  assign out_ch.end_offset   = out_offset_r;
  assign out_ch.overflowed   = out_ovf_r;
  assign out_ch.digits_found = out_any_r;

endmodule

@@ hdl/radix_string_to_int64.sv @@
// Channel   Dir  Handshake      Request contents
// in_ch     in   valid/ready    char_code[7:0], start_req
// out_ch    out  valid/ready    value[63:0] signed, end_offset[15:0], overflowed, digits_found
// cfg_ch    in   valid/ready    radix[5:0] (always ready)
//
// One character is taken every clock cycle while the queue is not full; the digit
// sequencer does one multiply-by-base, add and limit compare per cycle, which sets that rate.
// A result reaches out_ch once its terminating character, accepted into the queue,
// has been popped by the sequencer, which registers the result.
// Reset is synchronous; radix returns to 10 and no clearing pass is needed.
// A stalled out_ch holds the sequencer, and in_ch keeps flowing until the
// queue fills.
module radix_string_to_int64 #(
  parameter int OFFSET_WIDTH = 16,
  parameter int QUEUE_DEPTH  = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  rsti_in_if.sink     in_ch,
  rsti_out_if.source  out_ch,
  rsti_cfg_if.sink    cfg_ch
);
  import rsti_pkg::*;

  // The radix register. The user must write it only between strings; the block does not
  // enforce that. The sequencer simply samples it when the first significant character runs.
  logic [RADIX_W-1:0] radix_r, radix_nxt;

  // Front side: classified characters waiting for the sequencer.
  logic    push;
  cls_t    push_data;
  cls_t    head;
  q_stat_t q_stat;
  logic    pop;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    radix_nxt = radix_r;
    if (cfg_ch.valid) begin
      radix_nxt = cfg_ch.radix;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  // The front end decodes each byte into white space, sign, prefix and
  // digit value; none of that depends on conversion state.
  rsti_front u_front (
    .in_ch     (in_ch),
    .q_stat    (q_stat),
    .push      (push),
    .push_data (push_data)
  );

  // A short queue lets the input keep moving while a result waits.
  rsti_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // The back end walks the phases of the conversion, accumulates the
  // magnitude with saturation and registers the result.
  rsti_back #(
    .OFFSET_WIDTH (OFFSET_WIDTH)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .radix  (radix_r),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  // A result without digits carries nothing but zeros.
  a_no_digit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.digits_found) |->
      (out_ch.value == '0 && out_ch.end_offset == '0 && !out_ch.overflowed))
    else $error("result without digits is not zero");

  // Saturation only ever produces one of the two 64-bit limits.
  a_ovf_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.overflowed) |->
      (out_ch.value == MAG_POS_LIMIT || out_ch.value == MAG_NEG_LIMIT))
    else $error("overflowed result is not a limit value");

  // An empty queue never holds back the input side.
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.empty |-> in_ch.ready)
    else $error("input stalled with an empty queue");

  // The sequencer never takes an entry from an empty queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("sequencer popped an empty queue");

endmodule
